>>> design/cmr_pkg.sv
// Shared types, request and status codes for the chunked message reassembler.
package cmr_pkg;

  // Request type codes.
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_HEADER = 3'd1;
  localparam logic [2:0] REQ_BYTE   = 3'd2;
  localparam logic [2:0] REQ_COMMIT = 3'd3;
  localparam logic [2:0] REQ_ABORT  = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  // Result status codes.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_CMD   = 3'd1;
  localparam logic [2:0] STAT_BUSY      = 3'd2;
  localparam logic [2:0] STAT_TOO_LARGE = 3'd3;
  localparam logic [2:0] STAT_BAD_CHUNK = 3'd4;
  localparam logic [2:0] STAT_DUPLICATE = 3'd5;
  localparam logic [2:0] STAT_MISSING   = 3'd6;

  // One input word.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] msg_id;
    logic [15:0] msg_bytes;
    logic [7:0]  msg_chunks;
    logic [7:0]  chunk_number;
    logic [6:0]  chunk_len;
    logic [7:0]  data_byte;
    logic [11:0] read_address;
  } cmr_in_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] message_length;
    logic [7:0]  read_data;
  } cmr_out_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic        load;
    logic        from_ram;
    logic        read_zero;
    logic [2:0]  status;
    logic [12:0] length;
  } cmr_rsp_t;

  // Controller sequencing states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_HEADER
  } cmr_state_t;

endpackage

>>> design/chunked_message_reassembler_top.sv
// Top level of the chunked message reassembler: controller, message store, seen map, output register.
//
// Each request word yields exactly one result word. Payload byte and commit words, and start
// words that are refused, are answered straight from the decoder, so with the result side
// ready such words are taken every cycle; a chunk header and a read wait in ST_HEADER or
// ST_READ, because the seen map and the message store have registered read ports and the
// answer waits for the read data. After reset, after a successful start and after an abort,
// the store and the seen map are swept to zero one entry per cycle, which holds in_ready low
// until every entry of the larger of the two memories has been cleared. A new word is taken
// only when the output register is empty or is being emptied in the same cycle.
module chunked_message_reassembler_top #(
  parameter int MAX_BYTES   = 4096,
  parameter int CHUNK_BYTES = 64,
  parameter int MAX_CHUNKS  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cmr_pkg::cmr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cmr_pkg::cmr_out_t out_data
);
  import cmr_pkg::*;

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int SW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  cmr_rsp_t      rsp;
  logic          out_free;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          seen_we;
  logic [SW-1:0] seen_waddr;
  logic          seen_wdata;
  logic          seen_re;
  logic [SW-1:0] seen_raddr;
  logic          seen_rdata;

  assign out_free = !out_valid || out_ready;

  cmr_ctrl #(
    .MAX_BYTES  (MAX_BYTES),
    .CHUNK_BYTES(CHUNK_BYTES),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_free  (out_free),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .seen_we   (seen_we),
    .seen_waddr(seen_waddr),
    .seen_wdata(seen_wdata),
    .seen_re   (seen_re),
    .seen_raddr(seen_raddr),
    .seen_rdata(seen_rdata)
  );

  cmr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // One bit per chunk index, set when that chunk's header is accepted.
  cmr_ram #(
    .WIDTH(1),
    .DEPTH(MAX_CHUNKS)
  ) u_seen (
    .clk  (clk),
    .we   (seen_we),
    .waddr(seen_waddr),
    .wdata(seen_wdata),
    .re   (seen_re),
    .raddr(seen_raddr),
    .rdata(seen_rdata)
  );

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (rsp.load) begin
      out_data.status         <= rsp.status;
      out_data.message_length <= rsp.length;
      if (rsp.from_ram && !rsp.read_zero) begin
        out_data.read_data <= ram_rdata;
      end else begin
        out_data.read_data <= 8'd0;
      end
    end
  end

endmodule

>>> design/cmr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/cmr_ctrl.sv
// Request decoder, task registers and store sequencer of the reassembler.
module cmr_ctrl #(
  parameter int MAX_BYTES   = 4096,
  parameter int CHUNK_BYTES = 64,
  parameter int MAX_CHUNKS  = 64,
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
  localparam int SW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cmr_pkg::cmr_in_t in_data,
  input  logic            out_free,
  output cmr_pkg::cmr_rsp_t rsp,
  output logic            ram_we,
  output logic [AW-1:0]   ram_waddr,
  output logic [7:0]      ram_wdata,
  output logic            ram_re,
  output logic [AW-1:0]   ram_raddr,
  output logic            seen_we,
  output logic [SW-1:0]   seen_waddr,
  output logic            seen_wdata,
  output logic            seen_re,
  output logic [SW-1:0]   seen_raddr,
  input  logic            seen_rdata
);
  import cmr_pkg::*;

  localparam int BW      = $clog2(MAX_BYTES + 1);
  localparam int CW      = $clog2(MAX_CHUNKS + 1);
  localparam int RAW     = (AW > 12) ? AW : 12;
  localparam int CLEAR_N = (MAX_BYTES > MAX_CHUNKS) ? MAX_BYTES : MAX_CHUNKS;
  localparam int CLW     = (CLEAR_N > 1) ? $clog2(CLEAR_N) : 1;

  cmr_state_t state, state_next;

  logic [CLW-1:0]        clear_addr;
  logic                  task_open;
  logic [15:0]           open_id;
  logic [BW-1:0]         open_total_bytes;
  logic [CW-1:0]         open_total_chunks;
  logic [CW-1:0]         chunks_received;
  logic [BW-1:0]         bytes_received;
  logic [AW-1:0]         write_position;
  logic [6:0]            bytes_pending;
  logic                  read_zero;
  logic [15:0]           hdr_id;
  logic [7:0]            hdr_chunks;
  logic [7:0]            hdr_index;
  logic [6:0]            hdr_len;

  logic        accept;
  logic        clear_last;
  logic        store_clear;
  logic        seen_clear;
  logic [2:0]  dec_status;
  logic [12:0] dec_length;
  logic        do_open;
  logic        do_byte;
  logic        do_abort;
  logic        is_read;
  logic        is_header;
  logic [2:0]  hdr_status;
  logic        hdr_ok;
  logic        hdr_take;

  logic [16:0]    bytes_w;
  logic [16:0]    total_w;
  logic [8:0]     chunks_w;
  logic [8:0]     total_chunks_w;
  logic [19:0]    hdr_end;
  logic [19:0]    hdr_offset;
  logic [RAW:0]   read_addr_w;
  logic           read_in_range;

  assign accept      = in_valid && in_ready;
  assign clear_last  = (clear_addr == CLW'(CLEAR_N - 1));
  assign store_clear = ({1'b0, clear_addr} < (CLW + 1)'(MAX_BYTES));
  assign seen_clear  = ({1'b0, clear_addr} < (CLW + 1)'(MAX_CHUNKS));
  assign is_read     = (in_data.req_type == REQ_READ);
  assign is_header   = (in_data.req_type == REQ_HEADER);
  assign hdr_take    = (state == ST_HEADER) && hdr_ok;

  // Operands widened so that comparisons cannot overflow.
  assign bytes_w        = {1'b0, in_data.msg_bytes};
  assign total_w        = 17'(open_total_bytes);
  assign chunks_w       = {1'b0, in_data.msg_chunks};
  assign total_chunks_w = 9'(open_total_chunks);
  assign hdr_offset     = 20'(hdr_index) * 20'(CHUNK_BYTES);
  assign hdr_end        = hdr_offset + 20'(hdr_len);
  assign read_addr_w    = (RAW + 1)'(in_data.read_address);
  assign read_in_range  = (read_addr_w < (RAW + 1)'(MAX_BYTES));

  // Request decode and status checks.
  always_comb begin
    dec_status = STAT_BAD_CMD;
    dec_length = '0;
    do_open    = 1'b0;
    do_byte    = 1'b0;
    do_abort   = 1'b0;
    unique case (in_data.req_type)
      REQ_START: begin
        priority if (task_open) begin
          dec_status = STAT_BUSY;
        end else if (bytes_w > 17'(MAX_BYTES)) begin
          dec_status = STAT_TOO_LARGE;
        end else if (in_data.msg_chunks == 8'd0) begin
          dec_status = STAT_BAD_CMD;
        end else if (chunks_w > 9'(MAX_CHUNKS)) begin
          dec_status = STAT_TOO_LARGE;
        end else begin
          dec_status = STAT_OK;
          do_open    = 1'b1;
        end
      end
      REQ_HEADER: begin
        // Answered on the next cycle, once the seen bit is back.
        dec_status = STAT_BAD_CHUNK;
      end
      REQ_BYTE: begin
        if (task_open && bytes_pending != 7'd0) begin
          dec_status = STAT_OK;
          do_byte    = 1'b1;
        end else begin
          dec_status = STAT_BAD_CHUNK;
        end
      end
      REQ_COMMIT: begin
        priority if (!task_open) begin
          dec_status = STAT_BAD_CMD;
        end else if (in_data.msg_id != open_id || bytes_w != total_w ||
                     chunks_w != total_chunks_w) begin
          dec_status = STAT_BAD_CMD;
        end else if (chunks_received != open_total_chunks ||
                     bytes_received != open_total_bytes || bytes_pending != 7'd0) begin
          dec_status = STAT_MISSING;
        end else begin
          dec_status = STAT_OK;
          dec_length = total_w[12:0];
        end
      end
      REQ_ABORT: begin
        dec_status = STAT_OK;
        do_abort   = 1'b1;
      end
      REQ_READ: begin
        dec_status = STAT_OK;
      end
      default: begin
        dec_status = STAT_BAD_CMD;
      end
    endcase
  end

  // Chunk header checks on the held header, with the seen bit from its memory.
  always_comb begin
    hdr_status = STAT_BAD_CHUNK;
    hdr_ok     = 1'b0;
    priority if (!task_open) begin
      hdr_status = STAT_BAD_CHUNK;
    end else if (hdr_id != open_id || {1'b0, hdr_chunks} != total_chunks_w) begin
      hdr_status = STAT_BAD_CHUNK;
    end else if (9'(hdr_index) >= total_chunks_w) begin
      hdr_status = STAT_BAD_CHUNK;
    end else if (11'(hdr_len) > 11'(CHUNK_BYTES)) begin
      hdr_status = STAT_BAD_CHUNK;
    end else if (seen_rdata) begin
      hdr_status = STAT_DUPLICATE;
    end else if (hdr_end > 20'(open_total_bytes)) begin
      hdr_status = STAT_BAD_CHUNK;
    end else begin
      hdr_status = STAT_OK;
      hdr_ok     = 1'b1;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (is_read) begin
            state_next = ST_READ;
          end else if (is_header) begin
            state_next = ST_HEADER;
          end else if (do_open || do_abort) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_HEADER: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Sequencer outputs: handshake, memory ports and result.
  always_comb begin
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = write_position;
    ram_wdata     = in_data.data_byte;
    ram_re        = 1'b0;
    ram_raddr     = read_addr_w[AW-1:0];
    seen_we       = 1'b0;
    seen_waddr    = hdr_index[SW-1:0];
    seen_wdata    = 1'b1;
    seen_re       = 1'b0;
    seen_raddr    = in_data.chunk_number[SW-1:0];
    rsp.load      = 1'b0;
    rsp.from_ram  = 1'b0;
    rsp.read_zero = read_zero;
    rsp.status    = dec_status;
    rsp.length    = dec_length;
    unique case (state)
      ST_CLEAR: begin
        ram_we     = store_clear;
        ram_waddr  = clear_addr[AW-1:0];
        ram_wdata  = 8'd0;
        seen_we    = seen_clear;
        seen_waddr = clear_addr[SW-1:0];
        seen_wdata = 1'b0;
      end
      ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          ram_we   = do_byte;
          ram_re   = is_read && read_in_range;
          seen_re  = is_header;
          rsp.load = !is_read && !is_header;
        end
      end
      ST_READ: begin
        rsp.load     = 1'b1;
        rsp.from_ram = 1'b1;
        rsp.status   = STAT_OK;
        rsp.length   = '0;
      end
      ST_HEADER: begin
        seen_we    = hdr_take;
        rsp.load   = 1'b1;
        rsp.status = hdr_status;
        rsp.length = '0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Sequencer state and clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR && !clear_last) begin
        clear_addr <= clear_addr + CLW'(1);
      end else begin
        clear_addr <= '0;
      end
    end
  end

  // Out-of-range read flag, held until the store data returns.
  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      read_zero <= !read_in_range;
    end
  end

  // Chunk header fields, held while the seen bit is read.
  always_ff @(posedge clk) begin
    if (accept && is_header) begin
      hdr_id     <= in_data.msg_id;
      hdr_chunks <= in_data.msg_chunks;
      hdr_index  <= in_data.chunk_number;
      hdr_len    <= in_data.chunk_len;
    end
  end

  // Task registers and payload write pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      task_open         <= 1'b0;
      open_id           <= '0;
      open_total_bytes  <= '0;
      open_total_chunks <= '0;
      chunks_received   <= '0;
      bytes_received    <= '0;
      write_position    <= '0;
      bytes_pending     <= '0;
    end else if (hdr_take) begin
      chunks_received <= chunks_received + CW'(1);
      bytes_received  <= bytes_received + BW'(hdr_len);
      write_position  <= hdr_offset[AW-1:0];
      bytes_pending   <= hdr_len;
    end else if (accept) begin
      priority if (do_abort) begin
        task_open         <= 1'b0;
        open_id           <= '0;
        open_total_bytes  <= '0;
        open_total_chunks <= '0;
        chunks_received   <= '0;
        bytes_received    <= '0;
        write_position    <= '0;
        bytes_pending     <= '0;
      end else if (do_open) begin
        task_open         <= 1'b1;
        open_id           <= in_data.msg_id;
        open_total_bytes  <= bytes_w[BW-1:0];
        open_total_chunks <= in_data.msg_chunks[CW-1:0];
        chunks_received   <= '0;
        bytes_received    <= '0;
        write_position    <= '0;
        bytes_pending     <= '0;
      end else if (do_byte) begin
        write_position <= write_position + AW'(1);
        bytes_pending  <= bytes_pending - 7'd1;
      end
    end
  end

`ifndef SYNTH
  // A read request is answered from the store on the following cycle.
  a_read_returns: assert property (@(posedge clk) disable iff (rst)
    (accept && is_read) |=> (rsp.load && rsp.from_ram))
    else $error("read request not answered in the next cycle");

  // A result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp.load |-> out_free)
    else $error("result loaded while the output register is full");

  // Payload bytes can only be pending inside an open task.
  a_pending_open: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != 7'd0) |-> task_open)
    else $error("payload bytes pending with no open task");

  // Never more chunks counted than were declared.
  a_chunk_count: assert property (@(posedge clk) disable iff (rst)
    chunks_received <= open_total_chunks)
    else $error("received chunk count exceeds declared count");

  // Payload writes happen only inside an open task and never during the sweep.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != ST_CLEAR) |-> (task_open && accept))
    else $error("store written outside an accepted payload byte");
`endif

endmodule
